// ----- design/tcwa_pkg.sv -----
// Shared types, codes and helper function of the track to cluster window association unit.
`timescale 1ns / 1ps

package tcwa_pkg;

    localparam int COORD_W = 31;
    localparam int DIST_W  = 32;
    localparam int TIME_W  = 47;
    localparam int SQ_W    = 64;
    localparam int COUNT_W = 8;
    localparam int CFG_INDEX_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_X    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_Y    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_WINDOW = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_CENTRE  = 8'd3;

    typedef enum logic [1:0] {
        ACT_PIXEL = 2'd0,
        ACT_LAST  = 2'd1,
        ACT_EMPTY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        VERD_ACCEPT  = 2'd0,
        VERD_SPATIAL = 2'd1,
        VERD_TIME    = 2'd2,
        VERD_EMPTY   = 2'd3
    } verdict_t;

    typedef struct packed {
        action_t                    action;
        logic                       last_cluster;
        logic signed [COORD_W-1:0]  intercept_x;
        logic signed [COORD_W-1:0]  intercept_y;
        logic signed [COORD_W-1:0]  centre_x;
        logic signed [COORD_W-1:0]  centre_y;
        logic signed [COORD_W-1:0]  pixel_x;
        logic signed [COORD_W-1:0]  pixel_y;
        logic [TIME_W-1:0]          cluster_time;
        logic [TIME_W-1:0]          track_time;
    } in_item_t;

    typedef struct packed {
        action_t              action;
        logic                 last_cluster;
        logic [DIST_W-1:0]    pixel_dx;
        logic [DIST_W-1:0]    pixel_dy;
        logic [DIST_W-1:0]    centre_dx;
        logic [DIST_W-1:0]    centre_dy;
        logic [TIME_W-1:0]    time_diff;
    } diff_item_t;

    typedef struct packed {
        verdict_t             verdict;
        logic                 track_done;
        logic [DIST_W-1:0]    dx;
        logic [DIST_W-1:0]    dy;
        logic [COUNT_W-1:0]   accepted_in_track;
    } win_item_t;

    typedef struct packed {
        verdict_t             verdict;
        logic                 new_closest;
        logic [COUNT_W-1:0]   accepted_in_track;
        logic                 track_done;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0]   window_x;
        logic [COORD_W-1:0]   window_y;
        logic [TIME_W-1:0]    time_window;
        logic                 use_centre;
    } cfg_t;

    function automatic logic [DIST_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
        logic signed [DIST_W-1:0] a_ext;
        logic signed [DIST_W-1:0] b_ext;
        a_ext = {a[COORD_W-1], a};
        b_ext = {b[COORD_W-1], b};
        return (a_ext >= b_ext) ? DIST_W'(a_ext - b_ext) : DIST_W'(b_ext - a_ext);
    endfunction

endpackage

// ----- design/tcwa_diff.sv -----
// Difference stage: absolute pixel, centre and time distances of one transaction.
`timescale 1ns / 1ps

module tcwa_diff import tcwa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output diff_item_t out_item
);

    logic       valid_reg;
    diff_item_t item_reg;
    diff_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        item_next.action       = in_item.action;
        item_next.last_cluster = in_item.last_cluster;
        item_next.pixel_dx     = abs_diff(in_item.intercept_x, in_item.pixel_x);
        item_next.pixel_dy     = abs_diff(in_item.intercept_y, in_item.pixel_y);
        item_next.centre_dx    = abs_diff(in_item.intercept_x, in_item.centre_x);
        item_next.centre_dy    = abs_diff(in_item.intercept_y, in_item.centre_y);
        item_next.time_diff    = (in_item.cluster_time >= in_item.track_time) ?
                                 (in_item.cluster_time - in_item.track_time) :
                                 (in_item.track_time - in_item.cluster_time);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- design/tcwa_window.sv -----
// Window stage: running per-cluster minima, spatial and time windows, per-track count.
`timescale 1ns / 1ps

module tcwa_window import tcwa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  diff_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output win_item_t  out_item
);

    logic               valid_reg;
    logic               valid_next;
    win_item_t          item_reg;
    win_item_t          item_next;
    logic [DIST_W-1:0]  nearest_dx_reg;
    logic [DIST_W-1:0]  nearest_dx_next;
    logic [DIST_W-1:0]  nearest_dy_reg;
    logic [DIST_W-1:0]  nearest_dy_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [DIST_W-1:0]  min_dx;
    logic [DIST_W-1:0]  min_dy;
    logic [DIST_W-1:0]  dx;
    logic [DIST_W-1:0]  dy;
    logic               spatial_fail;
    logic               time_fail;
    logic [COUNT_W-1:0] count_bumped;
    logic               take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        min_dx = (in_item.pixel_dx < nearest_dx_reg) ? in_item.pixel_dx : nearest_dx_reg;
        min_dy = (in_item.pixel_dy < nearest_dy_reg) ? in_item.pixel_dy : nearest_dy_reg;
        dx     = cfg.use_centre ? in_item.centre_dx : min_dx;
        dy     = cfg.use_centre ? in_item.centre_dy : min_dy;
        spatial_fail = (dx > {1'b0, cfg.window_x}) || (dy > {1'b0, cfg.window_y});
        time_fail    = in_item.time_diff > cfg.time_window;
        count_bumped = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    end

    always_comb begin
        valid_next      = 1'b0;
        nearest_dx_next = nearest_dx_reg;
        nearest_dy_next = nearest_dy_reg;
        count_next      = count_reg;
        item_next.verdict           = VERD_ACCEPT;
        item_next.track_done        = in_item.last_cluster;
        item_next.dx                = dx;
        item_next.dy                = dy;
        item_next.accepted_in_track = count_reg;
        case (in_item.action)
            ACT_PIXEL: begin
                nearest_dx_next = min_dx;
                nearest_dy_next = min_dy;
            end
            ACT_LAST: begin
                valid_next      = 1'b1;
                nearest_dx_next = '1;
                nearest_dy_next = '1;
                if (spatial_fail) begin
                    item_next.verdict = VERD_SPATIAL;
                end else if (time_fail) begin
                    item_next.verdict = VERD_TIME;
                end else begin
                    item_next.accepted_in_track = count_bumped;
                end
                count_next = in_item.last_cluster ? '0 : item_next.accepted_in_track;
            end
            ACT_EMPTY: begin
                valid_next      = 1'b1;
                nearest_dx_next = '1;
                nearest_dy_next = '1;
                count_next      = '0;
                item_next.verdict           = VERD_EMPTY;
                item_next.track_done        = 1'b1;
                item_next.accepted_in_track = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            nearest_dx_reg <= '1;
            nearest_dy_reg <= '1;
            count_reg      <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid && valid_next;
            end
            if (take) begin
                nearest_dx_reg <= nearest_dx_next;
                nearest_dy_reg <= nearest_dy_next;
                count_reg      <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    a_empty_clears_track: assert property (@(posedge aclk) disable iff (!aresetn)
        take && in_item.action == ACT_EMPTY |=>
            count_reg == '0 && nearest_dx_reg == '1 && nearest_dy_reg == '1)
        else $error("Empty track did not clear the track state.");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        take && in_item.action == ACT_LAST && !in_item.last_cluster |=>
            count_reg >= $past(count_reg))
        else $error("Accepted cluster count fell within a track.");

endmodule

// ----- design/tcwa_closest.sv -----
// Closest cluster stage: squared distances, best-so-far compare and the result register.
`timescale 1ns / 1ps

module tcwa_closest import tcwa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  win_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_item
);

    logic               sq_valid_reg;
    logic               sq_ready;
    logic [SQ_W-1:0]    sq_x_reg;
    logic [SQ_W-1:0]    sq_y_reg;
    verdict_t           sq_verdict_reg;
    logic               sq_done_reg;
    logic [COUNT_W-1:0] sq_count_reg;
    logic               res_valid_reg;
    result_t            res_reg;
    result_t            res_next;
    logic [SQ_W-1:0]    best_reg;
    logic [SQ_W-1:0]    best_next;
    logic [SQ_W-1:0]    dist_sq;
    logic               take_sq;

    assign in_ready = !sq_valid_reg || sq_ready;
    assign sq_ready = !res_valid_reg || out_ready;
    assign take_sq  = sq_valid_reg && sq_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (in_ready) begin
            sq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sq_x_reg       <= SQ_W'(in_item.dx) * SQ_W'(in_item.dx);
            sq_y_reg       <= SQ_W'(in_item.dy) * SQ_W'(in_item.dy);
            sq_verdict_reg <= in_item.verdict;
            sq_done_reg    <= in_item.track_done;
            sq_count_reg   <= in_item.accepted_in_track;
        end
    end

    always_comb begin
        dist_sq  = sq_x_reg + sq_y_reg;
        res_next.verdict           = sq_verdict_reg;
        res_next.new_closest       = (sq_verdict_reg == VERD_ACCEPT) && (dist_sq < best_reg);
        res_next.accepted_in_track = sq_count_reg;
        res_next.track_done        = sq_done_reg;
        if (sq_done_reg) begin
            best_next = '1;
        end else if (res_next.new_closest) begin
            best_next = dist_sq;
        end else begin
            best_next = best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            best_reg      <= '1;
        end else begin
            if (sq_ready) begin
                res_valid_reg <= sq_valid_reg;
            end
            if (take_sq) begin
                best_reg <= best_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_sq) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

    a_closest_only_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && res_reg.new_closest |-> res_reg.verdict == VERD_ACCEPT)
        else $error("New closest flagged on a rejected cluster.");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && res_reg.verdict == VERD_EMPTY |->
            res_reg.track_done && !res_reg.new_closest && res_reg.accepted_in_track == '0)
        else $error("Empty track result has wrong fields.");

    a_track_end_resets_best: assert property (@(posedge aclk) disable iff (!aresetn)
        take_sq && sq_done_reg |=> best_reg == '1)
        else $error("Best distance not cleared at the end of a track.");

endmodule

// ----- design/track_cluster_window_association_unit.sv -----
// Top level of the track to cluster window association unit.
`timescale 1ns / 1ps

// The unit takes one pixel transaction per clock while s_tready is high, and returns one result
// for every last pixel of a cluster and for every empty track, in order. Its path is a chain of
// five registers (input, distance, window, square, result), each handing on to the next whenever
// the stage after it is free, so throughput is one transaction per cycle while m_tready keeps the
// chain moving, and m_tready stalls only propagate back as far as the chain is full. Write
// configuration only while no transaction is in flight.

module track_cluster_window_association_unit import tcwa_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]      cfg_data,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // intercept_x[30:0], intercept_y[61:31], centre_x[92:62], centre_y[123:93],
    // pixel_x[154:124], pixel_y[185:155], cluster_time[232:186], track_time[279:233]
    input  logic [279:0]           s_tdata,
    // action[1:0]
    input  logic [1:0]             s_tuser,
    // last_cluster
    input  logic                   s_tlast,
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // new_closest[0], accepted_in_track[8:1], zero[15:9]
    output logic [15:0]            m_tdata,
    // verdict[1:0]
    output logic [1:0]             m_tuser,
    // track_done
    output logic                   m_tlast
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    in_item_t   in_item_reg;
    in_item_t   in_item_next;
    logic       diff_ready;
    logic       diff_valid;
    diff_item_t diff_item;
    logic       win_ready;
    logic       win_valid;
    win_item_t  win_item;
    logic       close_ready;
    result_t    result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WINDOW_X:    cfg_reg.window_x    <= cfg_data[COORD_W-1:0];
                CFG_WINDOW_Y:    cfg_reg.window_y    <= cfg_data[COORD_W-1:0];
                CFG_TIME_WINDOW: cfg_reg.time_window <= cfg_data;
                CFG_USE_CENTRE:  cfg_reg.use_centre  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_item_next.action       = action_t'(s_tuser);
        in_item_next.last_cluster = s_tlast;
        in_item_next.intercept_x  = s_tdata[30:0];
        in_item_next.intercept_y  = s_tdata[61:31];
        in_item_next.centre_x     = s_tdata[92:62];
        in_item_next.centre_y     = s_tdata[123:93];
        in_item_next.pixel_x      = s_tdata[154:124];
        in_item_next.pixel_y      = s_tdata[185:155];
        in_item_next.cluster_time = s_tdata[232:186];
        in_item_next.track_time   = s_tdata[279:233];
    end

    assign s_tready = !in_valid_reg || diff_ready;

    // Transactions with the unused action code are taken and dropped here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid && (in_item_next.action != ACT_NONE);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
    end

    tcwa_diff u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (diff_ready),
        .in_item   (in_item_reg),
        .out_valid (diff_valid),
        .out_ready (win_ready),
        .out_item  (diff_item)
    );

    tcwa_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (diff_valid),
        .in_ready  (win_ready),
        .in_item   (diff_item),
        .out_valid (win_valid),
        .out_ready (close_ready),
        .out_item  (win_item)
    );

    tcwa_closest u_closest (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (win_valid),
        .in_ready  (close_ready),
        .in_item   (win_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (result)
    );

    assign m_tdata = {7'b0, result.accepted_in_track, result.new_closest};
    assign m_tuser = result.verdict;
    assign m_tlast = result.track_done;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the track to cluster window association unit.
`timescale 1ns / 1ps

module tb;
    import tcwa_pkg::*;

    localparam longint      MAX31        = 64'h7FFF_FFFF;
    localparam logic [46:0] MAX47        = '1;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 16;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [279:0]           s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [15:0]            m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;

    // Register copies and association state of the predictor.
    logic [30:0]  win_x_q    = '0;
    logic [30:0]  win_y_q    = '0;
    logic [46:0]  win_t_q    = '0;
    logic         centre_q   = 1'b0;
    logic [31:0]  near_dx    = '1;
    logic [31:0]  near_dy    = '1;
    logic [63:0]  best_sq    = '1;
    logic [7:0]   accept_cnt = '0;

    result_t expected_verdicts[$];

    int mismatches    = 0;
    int items_sent    = 0;
    int cycles        = 0;
    int snd_idle_pct  = 36;
    int rcv_idle_pct  = 72;
    int rcv_hold_req  = 0;
    int rcv_hold_left = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    track_cluster_window_association_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    function automatic logic [31:0] coord_dist(input logic [30:0] a, input logic [30:0] b);
        logic signed [32:0] d;
        d = $signed({{2{a[30]}}, a}) - $signed({{2{b[30]}}, b});
        return d[32] ? 32'(-d) : 32'(d);
    endfunction

    task automatic predict_verdict(input in_item_t it);
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [46:0] dt;
        logic [63:0] dsq;
        result_t     r;
        r.verdict           = VERD_EMPTY;
        r.new_closest       = 1'b0;
        r.accepted_in_track = '0;
        r.track_done        = 1'b1;
        case (it.action)
            ACT_EMPTY: begin
                near_dx    = '1;
                near_dy    = '1;
                best_sq    = '1;
                accept_cnt = '0;
                expected_verdicts.push_back(r);
            end
            ACT_PIXEL, ACT_LAST: begin
                qx = coord_dist(it.intercept_x, it.pixel_x);
                qy = coord_dist(it.intercept_y, it.pixel_y);
                if (qx < near_dx) near_dx = qx;
                if (qy < near_dy) near_dy = qy;
                if (it.action == ACT_LAST) begin
                    if (centre_q) begin
                        dx = coord_dist(it.intercept_x, it.centre_x);
                        dy = coord_dist(it.intercept_y, it.centre_y);
                    end else begin
                        dx = near_dx;
                        dy = near_dy;
                    end
                    dt = (it.cluster_time >= it.track_time) ? it.cluster_time - it.track_time
                                                            : it.track_time - it.cluster_time;
                    if (dx > {1'b0, win_x_q} || dy > {1'b0, win_y_q}) begin
                        r.verdict = VERD_SPATIAL;
                    end else if (dt > win_t_q) begin
                        r.verdict = VERD_TIME;
                    end else begin
                        r.verdict = VERD_ACCEPT;
                        if (accept_cnt != COUNT_MAX) accept_cnt = accept_cnt + 8'd1;
                        dsq = {32'd0, dx} * {32'd0, dx} + {32'd0, dy} * {32'd0, dy};
                        if (dsq < best_sq) begin
                            best_sq       = dsq;
                            r.new_closest = 1'b1;
                        end
                    end
                    r.accepted_in_track = accept_cnt;
                    r.track_done        = it.last_cluster;
                    expected_verdicts.push_back(r);
                    near_dx = '1;
                    near_dy = '1;
                    if (it.last_cluster) begin
                        best_sq    = '1;
                        accept_cnt = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual verdict %0d count %0d",
                         $time, m_tuser, m_tdata[8:1]);
                mismatches++;
            end else begin
                want = expected_verdicts.pop_front();
                compare_field("verdict", 32'(want.verdict), 32'(m_tuser));
                compare_field("new_closest", 32'(want.new_closest), 32'(m_tdata[0]));
                compare_field("accepted_in_track", 32'(want.accepted_in_track),
                              32'(m_tdata[8:1]));
                compare_field("track_done", 32'(want.track_done), 32'(m_tlast));
                compare_field("padding", 32'd0, 32'(m_tdata[15:9]));
            end
        end
    end

    always @(negedge aclk) begin
        if (rcv_hold_req > 0) begin
            rcv_hold_left = rcv_hold_req;
            rcv_hold_req  = 0;
        end
        if (rcv_hold_left > 0) begin
            rcv_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("track_cluster_window_association_unit: mismatch");
        $finish;
    end

    function automatic in_item_t make_item(input action_t act, input logic last,
                                           input longint ix, input longint iy,
                                           input longint cx, input longint cy,
                                           input longint qx, input longint qy,
                                           input logic [46:0] ct, input logic [46:0] tt);
        in_item_t it;
        it.action       = act;
        it.last_cluster = last;
        it.intercept_x  = 31'(ix);
        it.intercept_y  = 31'(iy);
        it.centre_x     = 31'(cx);
        it.centre_y     = 31'(cy);
        it.pixel_x      = 31'(qx);
        it.pixel_y      = 31'(qy);
        it.cluster_time = ct;
        it.track_time   = tt;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.action       = action_t'($urandom_range(3));
        it.last_cluster = 1'($urandom_range(1));
        it.intercept_x  = 31'($urandom);
        it.intercept_y  = 31'($urandom);
        it.centre_x     = 31'($urandom);
        it.centre_y     = 31'($urandom);
        it.pixel_x      = 31'($urandom);
        it.pixel_y      = 31'($urandom);
        it.cluster_time = 47'({$urandom, $urandom});
        it.track_time   = 47'({$urandom, $urandom});
        return it;
    endfunction

    function automatic longint rand_offset(input longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.track_time, it.cluster_time, it.pixel_y, it.pixel_x,
                     it.centre_y, it.centre_x, it.intercept_y, it.intercept_x};
        s_tuser  <= it.action;
        s_tlast  <= it.last_cluster;
        do @(posedge aclk); while (!s_tready);
        predict_verdict(it);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input logic [46:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            CFG_WINDOW_X:    win_x_q  = value[30:0];
            CFG_WINDOW_Y:    win_y_q  = value[30:0];
            CFG_TIME_WINDOW: win_t_q  = value;
            CFG_USE_CENTRE:  centre_q = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input longint wx, input longint wy, input logic [46:0] tw,
                             input logic centre);
        wait_drained();
        cfg_write(CFG_WINDOW_X, 47'(wx));
        cfg_write(CFG_WINDOW_Y, 47'(wy));
        cfg_write(CFG_TIME_WINDOW, tw);
        cfg_write(CFG_USE_CENTRE, 47'(centre));
    endtask

    task automatic send_random_track(input int n_clusters);
        in_item_t    it;
        longint      ix;
        longint      iy;
        longint      cx;
        longint      cy;
        longint      rx;
        longint      ry;
        longint      rt;
        longint      d;
        logic [46:0] tt;
        logic [46:0] ct;
        logic        ends;
        int          npix;
        int          c;
        int          p;
        rx = longint'(win_x_q) * 2 + 3;
        ry = longint'(win_y_q) * 2 + 3;
        rt = longint'(win_t_q) * 2 + 3;
        if (rx > 2**29) rx = 2**29;
        if (ry > 2**29) ry = 2**29;
        if (rt > 64'hFFFF_FFFF) rt = 64'hFFFF_FFFF;
        ix = rand_offset(2**29 - 1);
        iy = rand_offset(2**29 - 1);
        tt = 47'({$urandom, $urandom});
        if (tt < 47'h2_0000_0000) tt = tt + 47'h2_0000_0000;
        else if (tt > MAX47 - 47'h2_0000_0000) tt = tt - 47'h2_0000_0000;
        ends = ($urandom_range(7) != 0);
        if (n_clusters == 0) begin
            it = random_item();
            it.action = ACT_EMPTY;
            send_item(it);
        end
        for (c = 0; c < n_clusters; c++) begin
            d  = longint'($urandom_range(0, 32'(rt)));
            ct = $urandom_range(1) ? tt + 47'(d) : tt - 47'(d);
            cx = ix + rand_offset(rx);
            cy = iy + rand_offset(ry);
            npix = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            for (p = 0; p < npix; p++) begin
                if ($urandom_range(31) == 0) send_item(random_item());
                send_item(make_item((p == npix - 1) ? ACT_LAST : ACT_PIXEL,
                                    (c == n_clusters - 1) && ends, ix, iy, cx, cy,
                                    ix + rand_offset(rx), iy + rand_offset(ry), ct, tt));
            end
        end
    endtask

    // Reset window settings are all zero, so only an exact hit is accepted.
    task automatic test_reset_defaults();
        send_item(make_item(ACT_NONE, 1'b1, 5, -5, 7, -7, 9, -9, 47'd11, 47'd13));
        send_item(make_item(ACT_EMPTY, 1'b0, 0, 0, 0, 0, 0, 0, 47'd0, 47'd0));
        send_item(make_item(ACT_LAST, 1'b0, 1000, -2000, 0, 0, 1000, -2000, 47'd777, 47'd777));
        send_item(make_item(ACT_LAST, 1'b0, 1000, -2000, 0, 0, 1000, -2000, 47'd777, 47'd777));
        send_item(make_item(ACT_LAST, 1'b1, 1000, -2000, 0, 0, 1001, -2000, 47'd777, 47'd777));
    endtask

    task automatic test_window_edges();
        configure(1, 1, 47'd1, 1'b0);
        send_item(make_item(ACT_LAST, 1'b0, 0, 0, 0, 0, -1, 1, 47'd100, 47'd101));
        send_item(make_item(ACT_LAST, 1'b0, 0, 0, 0, 0, 1, 0, 47'd102, 47'd100));
        send_item(make_item(ACT_LAST, 1'b1, 0, 0, 0, 0, 2, 0, 47'd0, MAX47));
    endtask

    task automatic test_nearest_pixel();
        configure(100, 100, 47'd50, 1'b0);
        send_item(make_item(ACT_PIXEL, 1'b0, 5000, 5000, 0, 0, 5500, 5010, 47'd60, 47'd60));
        send_item(make_item(ACT_PIXEL, 1'b0, 5000, 5000, 0, 0, 4990, 5500, 47'd60, 47'd60));
        send_item(make_item(ACT_LAST, 1'b0, 5000, 5000, 0, 0, 5005, 5300, 47'd60, 47'd60));
        send_item(make_item(ACT_PIXEL, 1'b1, 5000, 5000, 0, 0, 5050, 5050, 47'd60, 47'd60));
        send_item(make_item(ACT_LAST, 1'b1, 5000, 5000, 0, 0, 5200, 5000, 47'd60, 47'd10));
        send_item(make_item(ACT_PIXEL, 1'b0, 5000, 5000, 0, 0, 5001, 5001, 47'd60, 47'd60));
        send_item(make_item(ACT_EMPTY, 1'b0, 5000, 5000, 0, 0, 5001, 5001, 47'd60, 47'd60));
        send_item(make_item(ACT_LAST, 1'b1, 5000, 5000, 0, 0, 5150, 5000, 47'd60, 47'd60));
    endtask

    task automatic test_centre_mode();
        configure(1000, 1000, 47'd10, 1'b1);
        send_item(make_item(ACT_LAST, 1'b0, 0, 0, -1000, 1000, 900000, -900000,
                            47'd20, 47'd30));
        send_item(make_item(ACT_LAST, 1'b1, 0, 0, 1001, 0, 0, 0, 47'd20, 47'd20));
    endtask

    task automatic test_extremes();
        configure(MAX31, MAX31, MAX47, 1'b0);
        send_item(make_item(ACT_LAST, 1'b0, -(2**30), 2**30 - 1, 0, 0, 2**30 - 1, -(2**30),
                            47'd0, MAX47));
        send_item(make_item(ACT_LAST, 1'b0, 2**30 - 1, -(2**30), 0, 0, -(2**30), 2**30 - 1,
                            MAX47, 47'd0));
        configure(MAX31, MAX31, MAX47, 1'b1);
        send_item(make_item(ACT_LAST, 1'b1, -(2**30), -(2**30), 2**30 - 1, 2**30 - 1,
                            -(2**30), -(2**30), MAX47, MAX47));
    endtask

    task automatic test_random_mix(input int n_items, input int unsigned win_max,
                                   input int unsigned tw_max);
        int goal;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            configure($urandom_range(0, win_max), $urandom_range(0, win_max),
                      47'($urandom_range(0, tw_max)), 1'($urandom_range(1)));
            repeat (12) begin
                if (items_sent < goal) send_random_track($urandom_range(0, 5));
            end
        end
    endtask

    task automatic test_count_saturation();
        longint ix;
        longint iy;
        int     k;
        configure(MAX31, MAX31, MAX47, 1'b0);
        ix = rand_offset(2**29 - 1);
        iy = rand_offset(2**29 - 1);
        for (k = 0; k < 280; k++) begin
            send_item(make_item(ACT_LAST, k == 279, ix, iy, 0, 0,
                                ix + rand_offset(2**29), iy + rand_offset(2**29),
                                47'({$urandom, $urandom}), 47'({$urandom, $urandom})));
        end
    endtask

    // The result side holds off while the input keeps offering transactions.
    task automatic test_backpressure();
        longint ix;
        longint iy;
        int     k;
        configure($urandom_range(0, 2000), $urandom_range(0, 2000),
                  47'($urandom_range(0, 2000)), 1'b0);
        ix = rand_offset(2**29 - 1);
        iy = rand_offset(2**29 - 1);
        rcv_hold_req = 400;
        for (k = 0; k < 150; k++) begin
            send_item(make_item(ACT_LAST, $urandom_range(7) == 0, ix, iy, ix, iy,
                                ix + rand_offset(3000), iy + rand_offset(3000),
                                47'(k * 1000), 47'(k * 1000 + $urandom_range(0, 3000))));
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_window_edges();
        test_nearest_pixel();
        test_centre_mode();
        test_extremes();
        test_random_mix(300, 5000, 20000);
        test_random_mix(300, 1 << 24, 32'hFFFF_FFFF);
        snd_idle_pct = 72;
        rcv_idle_pct = 36;
        test_random_mix(300, 100, 1000);
        test_random_mix(300, 32'h7FFF_FFFF, 100);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_count_saturation();
        test_backpressure();
        test_random_mix(250, 1000000, 5000);
        wait_drained();
        if (mismatches == 0) begin
            $display("track_cluster_window_association_unit: match");
        end else begin
            $display("track_cluster_window_association_unit: mismatch");
        end
        $finish;
    end

endmodule
